// ===== rtl/dirty_block_marker_3d_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DIRTY_BLOCK_MARKER_3D_TOP_ASSERT_SVH
`define DIRTY_BLOCK_MARKER_3D_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dbm3d_pkg.sv =====
//------------------------------------------------------------------------------
// dbm3d_pkg
// Types, constants and register indices of the dirty block marker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package dbm3d_pkg;
    localparam int MAX_COLS   = 16;
    localparam int MAX_ROWS   = 16;
    localparam int MAX_LEVELS = 16;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LEV_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int MASK_DEPTH = MAX_COLS * MAX_ROWS * MAX_LEVELS;
    localparam int ADDR_W = COL_W + ROW_W + LEV_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TOL_SCALE  = 25600;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEVELS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_STEP   = 3'd7;

    localparam logic [1:0] DIR_Z = 2'd0;
    localparam logic [1:0] DIR_Y = 2'd1;
    localparam logic [1:0] DIR_X = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [11:0] cell_first;
        logic [11:0] cell_second;
        logic [23:0] depth;
        logic [3:0]  query_col;
        logic [3:0]  query_row;
        logic [3:0]  query_level;
    } t_in_word;

    typedef struct packed {
        logic [3:0] marked_count;
        logic       bit_value;
        logic       changed;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_DIV_START, ST_DIV_DEPTH, ST_SEL, ST_DIV_AXES,
        ST_FLAGS, ST_WRITE, ST_READ, ST_READ_WAIT, ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic mul;
        logic div_start;
        logic div_axes;
        logic sel;
        logic flags;
        logic write_step;
        logic read_take;
        logic out_load;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic write_done;
        logic is_read;
    } t_status;
endpackage

// ===== rtl/dbm3d_ram.sv =====
//------------------------------------------------------------------------------
// dbm3d_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbm3d_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dbm3d_div.sv =====
//------------------------------------------------------------------------------
// dbm3d_div
// Radix-2 restoring divider, one quotient bit per cycle, 40-bit operands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbm3d_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [39:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quot,
    output logic [39:0] o_rem
);
    logic [39:0] r_quot, n_quot;
    logic [40:0] r_rem, n_rem;
    logic [39:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [40:0] w_trial;

    always_comb begin
        w_trial = {r_rem[39:0], r_quot[39]};
        n_quot  = {r_quot[38:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd40;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= 41'd0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[39:0];
endmodule

// ===== rtl/dbm3d_ctrl.sv =====
//------------------------------------------------------------------------------
// dbm3d_ctrl
// Sequencer for clearing, marking and reading the block mask.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbm3d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dbm3d_pkg::t_status i_status,
    output dbm3d_pkg::t_cmd    o_cmd
);
    import dbm3d_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = (r_state == ST_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:     if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE:      if (i_in_valid) n_state = ST_MUL;
            ST_MUL:       n_state = i_status.is_read ? ST_READ : ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_DEPTH;
            ST_DIV_DEPTH: if (i_status.div_done) n_state = ST_SEL;
            ST_SEL:       n_state = ST_DIV_AXES;
            ST_DIV_AXES:  if (i_status.div_done) n_state = ST_FLAGS;
            ST_FLAGS:     n_state = ST_WRITE;
            ST_WRITE:     if (i_status.write_done) n_state = ST_OUT;
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_OUT;
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_CLEAR:     o_cmd.clear_step = 1'b1;
            ST_IDLE:      o_cmd.load = w_accept;
            ST_MUL:       o_cmd.mul = 1'b1;
            // The products are registered in the cycle before, so the dividers see them now.
            ST_DIV_START: o_cmd.div_start = 1'b1;
            ST_DIV_DEPTH: o_cmd.sel = i_status.div_done;
            ST_SEL:       o_cmd.div_axes = 1'b1;
            ST_DIV_AXES:  ;
            ST_FLAGS:     o_cmd.flags = 1'b1;
            ST_WRITE:     o_cmd.write_step = 1'b1;
            ST_READ:      o_cmd.read_take = 1'b0;
            ST_READ_WAIT: o_cmd.read_take = 1'b1;
            ST_OUT:       begin
                o_cmd.out_load = w_out_free;
                if (w_out_free) n_out_valid = 1'b1;
            end
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/dbm3d_dp.sv =====
//------------------------------------------------------------------------------
// dbm3d_dp
// Datapath: configuration, depth and axis division, mask writes and reads.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbm3d_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dbm3d_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dbm3d_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  dbm3d_pkg::t_in_word                   i_in,
    input  dbm3d_pkg::t_cmd                       i_cmd,
    output dbm3d_pkg::t_status                    o_status,
    output dbm3d_pkg::t_out_word                  o_out
);
    import dbm3d_pkg::*;

    // Configuration registers.
    logic [1:0]  r_dir;
    logic [8:0]  r_bsx, r_bsy, r_bsz;
    logic [4:0]  r_cols, r_rows, r_levs;
    logic [15:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_Z;
            r_bsx  <= 9'd1;
            r_bsy  <= 9'd1;
            r_bsz  <= 9'd1;
            r_cols <= 5'd16;
            r_rows <= 5'd16;
            r_levs <= 5'd16;
            r_step <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIRECTION:    r_dir  <= i_cfg_data[1:0];
                REG_BLOCK_SIZE_X: r_bsx  <= i_cfg_data[8:0];
                REG_BLOCK_SIZE_Y: r_bsy  <= i_cfg_data[8:0];
                REG_BLOCK_SIZE_Z: r_bsz  <= i_cfg_data[8:0];
                REG_BLOCK_COLS:   r_cols <= i_cfg_data[4:0];
                REG_BLOCK_ROWS:   r_rows <= i_cfg_data[4:0];
                REG_BLOCK_LEVELS: r_levs <= i_cfg_data[4:0];
                REG_DEPTH_STEP:   r_step <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    logic [15:0] w_s;
    assign w_s = (r_step == 16'd0) ? 16'd1 : r_step;

    t_in_word    r_in;
    logic [31:0] r_ss;
    logic [39:0] r_den, r_dscl;
    logic        r_changed;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.mul) begin
            r_ss   <= 32'(w_s) * 32'(w_s);
            r_den  <= 40'(w_s) * 40'(TOL_SCALE);
            r_dscl <= 40'(r_in.depth) * 40'(TOL_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_changed <= 1'b0;
        else if (i_cmd.load && !i_in.cmd) r_changed <= 1'b1;
    end

    // Three dividers: up and down share a start; the axis pass reuses those two and a third.
    logic        w_start_a, w_start_b;
    logic [39:0] w_num_a, w_den_a, w_num_b, w_den_b, w_num_c, w_den_c;
    logic [39:0] w_qa, w_ra, w_qb, w_rb, w_qc, w_rc;
    logic        w_da, w_db, w_dc;
    logic        w_dn_neg;
    logic [39:0] w_dn_mag;
    logic [39:0] r_cx, r_cy, r_cz;
    logic        r_dborder;
    logic        r_sign_dn;
    logic        r_axes;

    assign w_dn_neg = {8'd0, r_ss} > r_dscl;
    assign w_dn_mag = w_dn_neg ? ({8'd0, r_ss} - r_dscl) : (r_dscl - {8'd0, r_ss});
    assign w_start_a = i_cmd.div_start || i_cmd.div_axes;
    assign w_start_b = w_start_a;

    always_comb begin
        if (i_cmd.div_axes) begin
            w_num_a = r_cx; w_den_a = 40'(r_bsx == 9'd0 ? 9'd1 : r_bsx);
            w_num_b = r_cy; w_den_b = 40'(r_bsy == 9'd0 ? 9'd1 : r_bsy);
        end else begin
            w_num_a = r_dscl + {8'd0, r_ss}; w_den_a = r_den;
            w_num_b = w_dn_mag;              w_den_b = r_den;
        end
        w_num_c = r_cz; w_den_c = 40'(r_bsz == 9'd0 ? 9'd1 : r_bsz);
    end

    dbm3d_div u_div_a (.i_clk, .i_rst_n, .i_start(w_start_a), .i_num(w_num_a),
                       .i_den(w_den_a), .o_done(w_da), .o_quot(w_qa), .o_rem(w_ra));
    dbm3d_div u_div_b (.i_clk, .i_rst_n, .i_start(w_start_b), .i_num(w_num_b),
                       .i_den(w_den_b), .o_done(w_db), .o_quot(w_qb), .o_rem(w_rb));
    dbm3d_div u_div_c (.i_clk, .i_rst_n, .i_start(i_cmd.div_axes), .i_num(w_num_c),
                       .i_den(w_den_c), .o_done(w_dc), .o_quot(w_qc), .o_rem(w_rc));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_sign_dn <= w_dn_neg;
        if (i_cmd.sel) begin
            // A negative lower quotient truncates to zero or below; never equal when up > 0.
            r_dborder <= r_sign_dn ? (w_qa != 40'd0 || w_qb != 40'd0) : (w_qa != w_qb);
            case (r_dir)
                DIR_Y:   begin r_cx <= 40'(r_in.cell_second); r_cy <= w_qa;
                               r_cz <= 40'(r_in.cell_first); end
                DIR_X:   begin r_cx <= w_qa; r_cy <= 40'(r_in.cell_first);
                               r_cz <= 40'(r_in.cell_second); end
                default: begin r_cx <= 40'(r_in.cell_first); r_cy <= 40'(r_in.cell_second);
                               r_cz <= w_qa; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_axes <= 1'b0;
        else if (i_cmd.div_axes) r_axes <= 1'b1;
        else if (i_cmd.flags) r_axes <= 1'b0;
    end

    // Block indices and border flags.
    logic [39:0] r_qx, r_qy, r_qz;
    logic        r_xm, r_ym, r_zm, r_xb, r_yb, r_zb, r_valid_dir;
    logic [4:0]  w_ccols, w_crows, w_clevs;

    assign w_ccols = (r_cols > 5'(MAX_COLS))   ? 5'(MAX_COLS)   : r_cols;
    assign w_crows = (r_rows > 5'(MAX_ROWS))   ? 5'(MAX_ROWS)   : r_rows;
    assign w_clevs = (r_levs > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : r_levs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.flags) begin
            r_qx <= w_qa; r_qy <= w_qb; r_qz <= w_qc;
            r_xm <= w_qa >= 40'(r_cols);
            r_ym <= w_qb >= 40'(r_rows);
            r_zm <= w_qc >= 40'(r_levs);
            r_xb <= ((r_dir == DIR_X) ? r_dborder : (w_ra == 40'd0)) && (w_qa != 40'd0);
            r_yb <= ((r_dir == DIR_Y) ? r_dborder : (w_rb == 40'd0)) && (w_qb != 40'd0);
            r_zb <= ((r_dir == DIR_Z) ? r_dborder : (w_rc == 40'd0)) && (w_qc != 40'd0);
            r_valid_dir <= (r_dir != 2'd3);
        end
    end

    // Write sweep over the eight candidate blocks, one per cycle.
    logic [3:0]  r_wcnt;
    logic [3:0]  r_count;
    logic        w_lx, w_ly, w_lz, w_en, w_inr;
    logic [39:0] w_bx, w_by, w_bz;
    logic [ADDR_W-1:0] r_clr_addr, w_addr, w_ram_addr;
    logic        w_ram_we, w_ram_wd, w_ram_rd, r_clr_done;

    assign w_lx = r_wcnt[0];
    assign w_ly = r_wcnt[1];
    assign w_lz = r_wcnt[2];
    assign w_bx = r_qx - 40'(w_lx);
    assign w_by = r_qy - 40'(w_ly);
    assign w_bz = r_qz - 40'(w_lz);
    assign w_en = r_valid_dir && !r_wcnt[3]
        && (!w_lx || r_xb) && (!w_ly || r_yb) && (!w_lz || r_zb)
        && (w_lx || !r_xm) && (w_ly || !r_ym) && (w_lz || !r_zm);
    assign w_inr = (w_bx < 40'(w_ccols)) && (w_by < 40'(w_crows)) && (w_bz < 40'(w_clevs));
    assign w_addr = {w_bz[LEV_W-1:0], w_by[ROW_W-1:0], w_bx[COL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flags) begin
            r_wcnt  <= 4'd0;
            r_count <= 4'd0;
        end else if (i_cmd.write_step && !r_wcnt[3]) begin
            r_wcnt <= r_wcnt + 4'd1;
            if (w_en && w_inr) r_count <= r_count + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MASK_DEPTH - 1)) r_clr_done <= 1'b1;
        end
    end

    always_comb begin
        w_ram_we   = 1'b0;
        w_ram_wd   = 1'b1;
        w_ram_addr = {r_in.query_level[LEV_W-1:0], r_in.query_row[ROW_W-1:0],
                      r_in.query_col[COL_W-1:0]};
        if (i_cmd.clear_step) begin
            w_ram_we   = 1'b1;
            w_ram_wd   = 1'b0;
            w_ram_addr = r_clr_addr;
        end else if (i_cmd.write_step) begin
            w_ram_we   = w_en && w_inr;
            w_ram_addr = w_addr;
        end
    end

    dbm3d_ram #(.WIDTH(1), .DEPTH(MASK_DEPTH)) u_mask (
        .i_clk, .i_we(w_ram_we), .i_addr(w_ram_addr), .i_wdata(w_ram_wd), .o_rdata(w_ram_rd)
    );

    logic r_bit, w_q_ok;
    assign w_q_ok = (32'(r_in.query_col) < MAX_COLS) && (32'(r_in.query_row) < MAX_ROWS)
                 && (32'(r_in.query_level) < MAX_LEVELS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_take) r_bit <= w_ram_rd && w_q_ok;
    end

    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.marked_count <= r_in.cmd ? 4'd0 : r_count;
            r_out.bit_value    <= r_in.cmd ? r_bit : 1'b0;
            r_out.changed      <= r_changed;
        end
    end

    assign o_out = r_out;
    assign o_status.clear_done = r_clr_done || (i_cmd.clear_step &&
                                 r_clr_addr == ADDR_W'(MASK_DEPTH - 1));
    assign o_status.div_done   = w_da && w_db && (w_dc || !r_axes);
    assign o_status.write_done = r_wcnt[3];
    assign o_status.is_read    = r_in.cmd;
endmodule

// ===== rtl/dirty_block_marker_3d_top.sv =====
// One word at a time: the next word is taken only once the last result word is loaded.
// Two 40-bit restoring divider passes, one quotient bit per cycle, and an eight-write
// sweep set the mark time; a result word held by the receiver stalls only the output stage.
// After reset the mask memory is cleared, one entry a cycle, all 4096 entries before
// the first word is taken; configuration writes are taken throughout.
//------------------------------------------------------------------------------
// dirty_block_marker_3d_top
// Marks coarse 3D blocks as modified from depth samples and reads mask bits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module dirty_block_marker_3d_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dbm3d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dbm3d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dbm3d_pkg::t_in_word               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dbm3d_pkg::t_out_word              o_out_data
);
    import dbm3d_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    dbm3d_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    dbm3d_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_in(i_in_data),
        .i_cmd(w_cmd), .o_status(w_status), .o_out(o_out_data)
    );
endmodule

// ===== rtl/dbm3d_checker.sv =====
//------------------------------------------------------------------------------
// dbm3d_checker
// Port-level checks of the marker's handshakes and results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dirty_block_marker_3d_top_assert.svh"
module dbm3d_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input dbm3d_pkg::t_out_word o_out_data
);
    import dbm3d_pkg::*;

    `DBM_ASSERT_NXT(a_in_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `DBM_ASSERT_IMP(a_read_count, i_clk, i_rst_n, o_out_valid && o_out_data.bit_value, o_out_data.marked_count == 4'd0, "count on a read")
    `DBM_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_out_valid, o_out_data.marked_count <= 4'd8, "count above eight")
    `DBM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output dropped")
endmodule

bind dirty_block_marker_3d_top dbm3d_checker u_checker (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready, .o_out_data
);
